@@ rtl/rv32_pkg.sv @@
// Package for the RV32IM execute unit: opcodes, beat structs, sequencer states.
// No dependencies.
package rv32_pkg;

    localparam int unsigned REG_COUNT_DEF = 32;
    localparam int unsigned XLEN = 32;

    typedef enum logic [5:0] {
        OP_ADD = 6'd0, OP_SUB = 6'd1, OP_SLL = 6'd2, OP_SLT = 6'd3, OP_SLTU = 6'd4,
        OP_XOR = 6'd5, OP_SRL = 6'd6, OP_SRA = 6'd7, OP_OR = 6'd8, OP_AND = 6'd9,
        OP_ADDI = 6'd10, OP_SLTI = 6'd11, OP_SLTIU = 6'd12, OP_XORI = 6'd13,
        OP_ORI = 6'd14, OP_ANDI = 6'd15, OP_SLLI = 6'd16, OP_SRLI = 6'd17,
        OP_SRAI = 6'd18, OP_JAL = 6'd19, OP_JALR = 6'd20, OP_BEQ = 6'd21,
        OP_BNE = 6'd22, OP_BLT = 6'd23, OP_BGE = 6'd24, OP_BLTU = 6'd25,
        OP_BGEU = 6'd26, OP_LUI = 6'd27, OP_AUIPC = 6'd28, OP_MUL = 6'd29,
        OP_MULH = 6'd30, OP_MULHSU = 6'd31, OP_MULHU = 6'd32, OP_DIV = 6'd33,
        OP_DIVU = 6'd34, OP_REM = 6'd35, OP_REMU = 6'd36
    } t_opcode;

    typedef struct packed {
        logic [5:0]  opcode;
        logic [4:0]  dest_index;
        logic [4:0]  src1_index;
        logic [4:0]  src2_index;
        logic [31:0] immediate;
        logic [31:0] instr_pc;
    } t_exe_in;

    typedef struct packed {
        logic        writes_register;
        logic [4:0]  write_index;
        logic [31:0] write_value;
        logic [31:0] next_address;
        logic        branch_taken;
    } t_exe_out;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_MUL, ST_DIV, ST_FIN
    } t_state;

endpackage

@@ rtl/rv32im_execute_unit.sv @@
// Sequencing from start to o_done: ALU, jump and branch ops pass READ and FIN; multiply adds MUL
// (one 32x32 product, high word sign-corrected); divide and remainder add DIV (one quotient bit a cycle).
// busy is high from the accepting edge until the done beat; one item at a time.
// Reset (synchronous, active low) clears the sequencer and the register file.
// The done beat lasts one cycle; the receiver cannot stall.
module rv32im_execute_unit
    import rv32_pkg::*;
#(
    parameter int unsigned REGISTER_COUNT = REG_COUNT_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_exe_in  i_item,
    output logic     o_done,
    output t_exe_out o_result
);

    localparam int unsigned RI_W = $clog2(REGISTER_COUNT);

    t_state r_state, n_state;
    t_exe_in r_in;
    logic [31:0] r_regs [REGISTER_COUNT];
    logic [31:0] r_a, r_b;
    logic [5:0]  r_cnt, n_cnt;
    logic [31:0] r_q, r_rem, r_dvs;
    logic [63:0] r_prod;
    logic        r_qneg, r_rneg;
    logic        r_done;
    t_exe_out    r_out;

    t_opcode op;
    assign op = t_opcode'(r_in.opcode);

    function automatic logic [31:0] rd_reg(input logic [31:0] v, input logic [4:0] idx);
        rd_reg = (idx == 5'd0 || 32'(idx) >= REGISTER_COUNT) ? 32'd0 : v;
    endfunction

    // operand b: register or immediate
    logic imm_op;
    assign imm_op = (r_in.opcode >= 6'(OP_ADDI)) && (r_in.opcode <= 6'(OP_SRAI));
    logic [31:0] opb;
    assign opb = imm_op ? r_in.immediate : r_b;

    // shared subtractor/comparator; shift amount from operand b
    logic [32:0] sub_res;
    logic        lts, ltu;
    logic [31:0] alu, link, tgt;
    logic [4:0]  sh;
    logic        cond, is_br, wr;
    assign sub_res = {1'b0, r_a} - {1'b0, opb};
    assign ltu = sub_res[32];
    assign lts = (r_a[31] ^ opb[31]) ? r_a[31] : sub_res[32];
    assign sh = opb[4:0];
    assign link = r_in.instr_pc + 32'd4;

    always_comb begin
        alu = 32'd0;
        cond = 1'b0;
        is_br = 1'b0;
        wr = 1'b1;
        tgt = r_in.instr_pc + r_in.immediate;
        unique case (op)
            OP_ADD, OP_ADDI: alu = r_a + opb;
            OP_SUB: alu = sub_res[31:0];
            OP_SLL, OP_SLLI: alu = r_a << sh;
            OP_SLT, OP_SLTI: alu = {31'd0, lts};
            OP_SLTU, OP_SLTIU: alu = {31'd0, ltu};
            OP_XOR, OP_XORI: alu = r_a ^ opb;
            OP_SRL, OP_SRLI: alu = r_a >> sh;
            OP_SRA, OP_SRAI: alu = $unsigned($signed(r_a) >>> sh);
            OP_OR, OP_ORI: alu = r_a | opb;
            OP_AND, OP_ANDI: alu = r_a & opb;
            OP_JAL: begin
                alu = link;
                cond = 1'b1;
            end
            OP_JALR: begin
                alu = link;
                cond = 1'b1;
                tgt = (r_a + r_in.immediate) & ~32'd1;
            end
            OP_BEQ: begin is_br = 1'b1; cond = (sub_res[31:0] == 32'd0); end
            OP_BNE: begin is_br = 1'b1; cond = (sub_res[31:0] != 32'd0); end
            OP_BLT: begin is_br = 1'b1; cond = lts; end
            OP_BGE: begin is_br = 1'b1; cond = !lts; end
            OP_BLTU: begin is_br = 1'b1; cond = ltu; end
            OP_BGEU: begin is_br = 1'b1; cond = !ltu; end
            OP_LUI: alu = r_in.immediate;
            OP_AUIPC: alu = r_in.instr_pc + r_in.immediate;
            OP_MUL: alu = r_prod[31:0];
            OP_MULH, OP_MULHSU, OP_MULHU: alu = r_prod[63:32];
            OP_DIV, OP_DIVU: alu = r_q;
            OP_REM, OP_REMU: alu = r_rem;
            default: wr = 1'b0;
        endcase
        if (is_br) begin
            wr = 1'b0;
        end
    end

    // multiply: unsigned 32x32 then sign corrections on the high word
    logic [63:0] umul;
    assign umul = {32'd0, r_a} * {32'd0, r_b};
    logic [31:0] hcorr;
    always_comb begin
        hcorr = 32'd0;
        if ((op == OP_MULH || op == OP_MULHSU) && r_a[31]) begin
            hcorr = hcorr + r_b;
        end
        if (op == OP_MULH && r_b[31]) begin
            hcorr = hcorr + r_a;
        end
    end

    // divide: restoring, one bit per cycle on magnitudes
    logic sdiv;
    assign sdiv = (op == OP_DIV) || (op == OP_REM);
    logic [32:0] trial;
    assign trial = {r_rem, r_q[31]} - {1'b0, r_dvs};

    logic do_div_init, do_div_step, do_mul;
    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        do_div_init = 1'b0;
        do_div_step = 1'b0;
        do_mul = 1'b0;
        unique case (r_state)
            ST_IDLE: if (start) begin
                n_state = ST_READ;
            end
            ST_READ: begin
                if (op == OP_MUL || op == OP_MULH || op == OP_MULHSU || op == OP_MULHU) begin
                    n_state = ST_MUL;
                end else if (op == OP_DIV || op == OP_DIVU || op == OP_REM || op == OP_REMU)
                begin
                    n_state = ST_DIV;
                    do_div_init = 1'b1;
                    n_cnt = 6'd0;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_MUL: begin
                do_mul = 1'b1;
                n_state = ST_FIN;
            end
            ST_DIV: begin
                do_div_step = 1'b1;
                if (r_cnt == 6'd33) begin
                    n_state = ST_FIN;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            ST_FIN: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt <= 6'd0;
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_done <= (r_state == ST_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_in <= i_item;
        end
        if (r_state == ST_READ) begin
            r_a <= rd_reg(r_regs[r_in.src1_index[RI_W-1:0]], r_in.src1_index);
            r_b <= rd_reg(r_regs[r_in.src2_index[RI_W-1:0]], r_in.src2_index);
        end
        if (do_mul) begin
            r_prod <= {umul[63:32] - hcorr, umul[31:0]};
        end
        if (do_div_init) begin
            r_qneg <= 1'b0;
            r_rneg <= 1'b0;
        end
        if (r_state == ST_DIV && r_cnt == 6'd0) begin
            // load magnitudes
            r_q <= (sdiv && r_a[31]) ? 32'd0 - r_a : r_a;
            r_dvs <= (sdiv && r_b[31]) ? 32'd0 - r_b : r_b;
            r_rem <= 32'd0;
            r_qneg <= sdiv && (r_a[31] ^ r_b[31]) && (r_b != 32'd0);
            r_rneg <= sdiv && r_a[31];
        end else if (do_div_step && r_cnt != 6'd33) begin
            if (!trial[32]) begin
                r_rem <= trial[31:0];
                r_q <= {r_q[30:0], 1'b1};
            end else begin
                r_rem <= {r_rem[30:0], r_q[31]};
                r_q <= {r_q[30:0], 1'b0};
            end
        end else if (do_div_step) begin
            // sign fix; zero divisor gives q all ones, rem dividend naturally
            r_q <= r_qneg ? 32'd0 - r_q : r_q;
            r_rem <= r_rneg ? 32'd0 - r_rem : r_rem;
        end
        if (r_state == ST_FIN) begin
            r_out.writes_register <= wr && (r_in.dest_index != 5'd0)
                && (32'(r_in.dest_index) < REGISTER_COUNT);
            r_out.write_index <= (wr && r_in.dest_index != 5'd0
                && 32'(r_in.dest_index) < REGISTER_COUNT) ? r_in.dest_index : 5'd0;
            r_out.write_value <= (wr && r_in.dest_index != 5'd0
                && 32'(r_in.dest_index) < REGISTER_COUNT) ? alu : 32'd0;
            r_out.next_address <= cond ? tgt : link;
            r_out.branch_taken <= cond;
        end
    end

    // register file; entry zero never written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REGISTER_COUNT; i++) begin
                r_regs[i] <= 32'd0;
            end
        end else if (r_state == ST_FIN && wr && r_in.dest_index != 5'd0
                     && 32'(r_in.dest_index) < REGISTER_COUNT) begin
            r_regs[r_in.dest_index[RI_W-1:0]] <= alu;
        end
    end

    assign busy = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_result = r_out;

`ifndef SYNTHESIS
    a_done_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == ST_FIN)) else $error("done without finish");
    a_no_x0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_result.writes_register && o_result.write_index == 5'd0))
        else $error("write to register zero");
    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("start not taken");
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 6'd33) else $error("divide count overrun");
`endif

endmodule
